@@ hw/rtl/bllie_pkg.sv @@
// ----------------------------------------------------------------------------
// bllie_pkg : shared types and constants for the level list unit
// Sizes, operation and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package bllie_pkg;

    localparam int CAPACITY   = 16;
    localparam int ENTRY_BITS = 64;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SLOT_W = 5;
    localparam int WIDE_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    localparam int OP_W     = 3;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 72;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_ERASE  = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_CLEAR
    } cell_kind_t;

    // broadcast to every cell in the accept cycle
    typedef struct packed {
        cell_kind_t             kind;
        logic [CNT_W-1:0]       pos;
        logic [CNT_W-1:0]       lim;
        logic [ENTRY_BITS-1:0]  word;
    } cell_cmd_t;

    typedef struct packed {
        status_t           status;
        logic              rd_en;
        logic [CNT_W-1:0]  count;
    } op_result_t;

endpackage

@@ hw/rtl/bounded_level_list_insert_erase_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_level_list_insert_erase_unit : fixed-capacity ordered level list
// Append, insert, erase, read, write and clear on a chain of entry cells.
// ----------------------------------------------------------------------------
//
//  channel   direction  beat contents (low bit first)
//  s_axis    in         operation[2:0], slot_index[7:3], entry_word[71:8]
//  m_axis    out        status[1:0], read_word[65:2], fill_count[70:66],
//                       is_empty[71]
//
//  One operation per cycle while the result register is free or draining:
//  every cell takes its new value from itself, its left or right neighbour
//  or the broadcast word in the accept cycle, so a shift completes at once.
//  The result beat appears the cycle after acceptance and is held until
//  taken; a new beat is accepted in the same cycle the held one leaves.
//  Reset zeroes every cell and the fill count; no clearing pass is needed.
//  Read returns the slot content before any change made by the same beat.
//
module bounded_level_list_insert_erase_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // operation, slot_index, entry_word
    input  logic [bllie_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status, read_word, fill_count, is_empty
    output logic [bllie_pkg::OUT_W-1:0]   m_axis_tdata
);
    import bllie_pkg::*;

    logic                   accept;
    logic [OP_W-1:0]        operation;
    logic [SLOT_W-1:0]      slot_index;
    logic [ENTRY_BITS-1:0]  entry_word;
    logic [WIDE_W-1:0]      idx_w;
    cell_cmd_t              cmd;
    op_result_t             result;

    logic [ENTRY_BITS-1:0]  cell_word  [CAPACITY];
    logic [ENTRY_BITS-1:0]  left_word  [CAPACITY];
    logic [ENTRY_BITS-1:0]  right_word [CAPACITY];

    logic [WORD_W-1:0]      read_word;
    logic [FILL_W-1:0]      fill_count;
    logic                   is_empty;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_W-1:0]       out_data_reg;
    logic [OUT_W-1:0]       out_data_next;

    // unpack the input beat; entry kept to its low ENTRY_BITS bits
    assign operation  = s_axis_tdata[OP_W-1:0];
    assign slot_index = s_axis_tdata[OP_W+SLOT_W-1:OP_W];
    assign entry_word = s_axis_tdata[OP_W+SLOT_W+ENTRY_BITS-1:OP_W+SLOT_W];
    assign idx_w      = WIDE_W'(slot_index);

    // output register frees up when empty or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bllie_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .slot_index (slot_index),
        .entry_word (entry_word),
        .cmd        (cmd),
        .result     (result)
    );

    // the cell chain; the ends see zero from beyond
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_word[gi] = '0;
            end
            else
            begin : g_inner_l
                assign left_word[gi] = cell_word[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_word[gi] = '0;
            end
            else
            begin : g_inner_r
                assign right_word[gi] = cell_word[gi+1];
            end

            bllie_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_idx   (CNT_W'(gi)),
                .cmd        (cmd),
                .left_word  (left_word[gi]),
                .right_word (right_word[gi]),
                .word       (cell_word[gi])
            );
        end
    endgenerate

    // read tap: slot select over the current cell contents
    assign read_word  = result.rd_en ? WORD_W'(cell_word[idx_w[IDX_W-1:0]]) : '0;
    assign fill_count = FILL_W'(result.count);
    assign is_empty   = result.count == '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {is_empty, fill_count, read_word, result.status};
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ hw/rtl/bllie_cell.sv @@
// ----------------------------------------------------------------------------
// bllie_cell : one slot of the level list
// Holds one entry; loads, takes from a neighbour, zeroes or holds.
// ----------------------------------------------------------------------------
module bllie_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bllie_pkg::CNT_W-1:0]    cell_idx,
    input  bllie_pkg::cell_cmd_t           cmd,
    input  logic [bllie_pkg::ENTRY_BITS-1:0] left_word,
    input  logic [bllie_pkg::ENTRY_BITS-1:0] right_word,
    output logic [bllie_pkg::ENTRY_BITS-1:0] word
);
    import bllie_pkg::*;

    logic [ENTRY_BITS-1:0] word_reg;
    logic [ENTRY_BITS-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (cmd.kind)
            CELL_LOAD:
            begin
                if (cell_idx == cmd.pos)
                    word_next = cmd.word;
            end
            CELL_INSERT:
            begin
                // lim is the new count; the entry at the old top drops off when full
                if (cell_idx == cmd.pos)
                    word_next = cmd.word;
                else if (cell_idx > cmd.pos && cell_idx < cmd.lim)
                    word_next = left_word;
            end
            CELL_ERASE:
            begin
                // lim is the last valid slot before the erase
                if (cell_idx == cmd.lim)
                    word_next = '0;
                else if (cell_idx >= cmd.pos && cell_idx < cmd.lim)
                    word_next = right_word;
            end
            CELL_CLEAR:
                word_next = '0;
            default:
                word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

@@ hw/rtl/bllie_ctrl.sv @@
// ----------------------------------------------------------------------------
// bllie_ctrl : operation decode and fill count
// Checks bounds, keeps the count and builds the cell command.
// ----------------------------------------------------------------------------
module bllie_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [bllie_pkg::OP_W-1:0]        operation,
    input  logic [bllie_pkg::SLOT_W-1:0]      slot_index,
    input  logic [bllie_pkg::ENTRY_BITS-1:0]  entry_word,
    output bllie_pkg::cell_cmd_t              cmd,
    output bllie_pkg::op_result_t             result
);
    import bllie_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WIDE_W-1:0] idx_w;
    logic [WIDE_W-1:0] cnt_w;
    logic              in_cap;
    logic              below_cnt;
    logic              full;
    logic [CNT_W-1:0]  idx_c;
    op_t               op;
    status_t           status;
    logic              rd_en;
    cell_cmd_t         cmd_c;

    assign op        = op_t'(operation);
    assign idx_w     = WIDE_W'(slot_index);
    assign cnt_w     = WIDE_W'(count_reg);
    assign idx_c     = idx_w[CNT_W-1:0];
    assign in_cap    = idx_w < WIDE_W'(CAPACITY);
    assign below_cnt = idx_w < cnt_w;
    assign full      = count_reg == CNT_W'(CAPACITY);

    always_comb
    begin
        cmd_c.kind = CELL_HOLD;
        cmd_c.pos  = '0;
        cmd_c.lim  = '0;
        cmd_c.word = entry_word;
        status     = ST_DONE;
        rd_en      = 1'b0;
        count_next = count_reg;
        case (op)
            OP_APPEND:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    cmd_c.kind = CELL_LOAD;
                    cmd_c.pos  = count_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (!in_cap)
                    status = ST_IGNORED;
                else
                begin
                    cmd_c.kind = CELL_INSERT;
                    cmd_c.pos  = below_cnt ? idx_c : count_reg;
                    cmd_c.lim  = full ? CNT_W'(CAPACITY) : count_reg + CNT_W'(1);
                    count_next = cmd_c.lim;
                end
            end
            OP_ERASE:
            begin
                if (!below_cnt)
                    status = ST_IGNORED;
                else
                begin
                    cmd_c.kind = CELL_ERASE;
                    cmd_c.pos  = idx_c;
                    cmd_c.lim  = count_reg - CNT_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (!in_cap)
                    status = ST_RANGE;
                else
                    rd_en = 1'b1;
            end
            OP_WRITE:
            begin
                if (!in_cap)
                    status = ST_RANGE;
                else
                begin
                    cmd_c.kind = CELL_LOAD;
                    cmd_c.pos  = idx_c;
                end
            end
            OP_CLEAR:
            begin
                cmd_c.kind = CELL_CLEAR;
                count_next = '0;
            end
            default:
                status = ST_IGNORED;
        endcase
    end

    always_comb
    begin
        cmd = cmd_c;
        if (!accept)
            cmd.kind = CELL_HOLD;
    end

    assign result.status = status;
    assign result.rd_en  = rd_en;
    assign result.count  = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

endmodule

@@ hw/rtl/bllie_checker.sv @@
// ----------------------------------------------------------------------------
// bllie_checker : port-level checks for the level list unit
// Watches the result stream for consistent status, count and read data.
// ----------------------------------------------------------------------------
module bllie_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [bllie_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [bllie_pkg::OUT_W-1:0]   m_axis_tdata
);
    import bllie_pkg::*;

    // held result beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // empty flag only with a zero count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[71] |-> m_axis_tdata[70:66] == '0)
        else $error("empty flag with non-zero fill count");

    // full report only at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL
        |-> m_axis_tdata[70:66] == FILL_W'(CAPACITY))
        else $error("full status below capacity");

    // read data only on a successful operation
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_DONE |-> m_axis_tdata[65:2] == '0)
        else $error("read word non-zero on failed operation");

    // an accepted beat always yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

endmodule

bind bounded_level_list_insert_erase_unit bllie_checker u_bllie_checker (.*);

@@ bench/level_list_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// level_list_checker : result checking for the level list unit
// Watches both stream channels. Every accepted operation beat runs through a
// behavioural copy of the list, and every result beat is checked against the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module level_list_checker
    import bllie_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               mismatches,
    output int               outstanding,
    output int               beats_checked
);

    typedef struct packed {
        status_t               status;
        logic [WORD_W-1:0]     read_word;
        logic [FILL_W-1:0]     fill_count;
        logic                  is_empty;
    } list_result_t;

    logic [ENTRY_BITS-1:0] shadow_store [CAPACITY];
    int                    shadow_count;
    list_result_t          predicted_results [$];

    initial
    begin
        mismatches    = 0;
        outstanding   = 0;
        beats_checked = 0;
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t ns  MISMATCH %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // one list operation on the shadow copy; returns the result beat it causes
    task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                 input logic [WORD_W-1:0] word, output list_result_t res);
        int                    idx;
        int                    pos;
        int                    new_count;
        logic [ENTRY_BITS-1:0] entry;
        idx            = int'(slot);
        entry          = word[ENTRY_BITS-1:0];
        res.status     = ST_DONE;
        res.read_word  = '0;
        case (op)
            OP_APPEND:
                if (shadow_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    shadow_store[shadow_count] = entry;
                    shadow_count++;
                end
            OP_INSERT:
                if (idx >= CAPACITY)
                    res.status = ST_IGNORED;
                else
                begin
                    // past the end lands at the end; a full list loses its last entry
                    pos       = (idx < shadow_count) ? idx : shadow_count;
                    new_count = (shadow_count + 1 < CAPACITY) ? shadow_count + 1 : CAPACITY;
                    for (int i = new_count; i > pos + 1; i--)
                        shadow_store[i - 1] = shadow_store[i - 2];
                    shadow_store[pos] = entry;
                    shadow_count      = new_count;
                end
            OP_ERASE:
                if (idx >= shadow_count)
                    res.status = ST_IGNORED;
                else
                begin
                    for (int i = idx + 1; i < shadow_count; i++)
                        shadow_store[i - 1] = shadow_store[i];
                    shadow_count--;
                    shadow_store[shadow_count] = '0;
                end
            OP_READ:
                if (idx >= CAPACITY)
                    res.status = ST_RANGE;
                else
                    res.read_word = WORD_W'(shadow_store[idx]);
            OP_WRITE:
                if (idx >= CAPACITY)
                    res.status = ST_RANGE;
                else
                    shadow_store[idx] = entry;
            OP_CLEAR:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    shadow_store[i] = '0;
                shadow_count = 0;
            end
            default:
                res.status = ST_IGNORED;
        endcase
        res.fill_count = FILL_W'(shadow_count);
        res.is_empty   = (shadow_count == 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t      want;
        list_result_t      res;
        logic [WORD_W-1:0] got_word;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                shadow_store[i] = '0;
            shadow_count = 0;
            predicted_results.delete();
            outstanding = 0;
        end
        else
        begin
            // result side first: a beat leaving now belongs to an earlier operation
            if (m_tvalid && m_tready)
            begin
                beats_checked++;
                got_word = m_tdata[STATUS_W +: WORD_W];
                if (predicted_results.size() == 0)
                    report_mismatch("result beat with nothing outstanding", got_word, '0);
                else
                begin
                    want = predicted_results.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== want.status)
                        report_mismatch("status", WORD_W'(m_tdata[STATUS_W-1:0]),
                                        WORD_W'(want.status));
                    if (got_word !== want.read_word)
                        report_mismatch("read_word", got_word, want.read_word);
                    if (m_tdata[STATUS_W + WORD_W +: FILL_W] !== want.fill_count)
                        report_mismatch("fill_count",
                                        WORD_W'(m_tdata[STATUS_W + WORD_W +: FILL_W]),
                                        WORD_W'(want.fill_count));
                    if (m_tdata[STATUS_W + WORD_W + FILL_W] !== want.is_empty)
                        report_mismatch("is_empty",
                                        WORD_W'(m_tdata[STATUS_W + WORD_W + FILL_W]),
                                        WORD_W'(want.is_empty));
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_list_op(s_tdata[OP_W-1:0], s_tdata[OP_W +: SLOT_W],
                              s_tdata[OP_W + SLOT_W +: WORD_W], res);
                predicted_results.push_back(res);
            end
            outstanding = predicted_results.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : stimulus and verdict for the level list unit
// Drives a short directed run over the corner cases, then phases of random
// operations that fill, drain or churn the list, with bursty input and a
// stalling output. Checking is left to the list checker beside the unit.
// ----------------------------------------------------------------------------
module tb_top;
    import bllie_pkg::*;

    // the two operation codes the unit does not use; both must come back ignored
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // flavour of a random phase
    localparam int FILL_PHASE  = 0;
    localparam int DRAIN_PHASE = 1;
    localparam int MIXED_PHASE = 2;

    // output-side stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_PULSE  = 3;

    localparam int RANDOM_BEATS = 1250;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tready = 1'b0;
    wire              s_axis_tready;
    wire              m_axis_tvalid;
    wire  [OUT_W-1:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int beats_checked;

    int burst_left = 0;   // beats left in the current input burst
    int op_tally [8];     // beats sent per operation code
    int rx_mode    = RX_OPEN;
    int rx_left    = 0;
    int rx_tick    = 0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bounded_level_list_insert_erase_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    level_list_checker u_list_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .beats_checked (beats_checked)
    );

    // Result side: a stall pattern is held for a random stretch, then swapped.
    // The open pattern gives stretches with no back-pressure at all.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(RX_OPEN, RX_PULSE);
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= ((rx_tick % 5) < 3);
        endcase
    end

    // Send one operation beat and hold it until the unit takes it.
    // Bursts of random length are separated by random gaps with tvalid low;
    // the odd long burst runs back to back.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [WORD_W-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tdata  <= {word, slot, op};
        s_axis_tvalid <= 1'b1;
        op_tally[op]++;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Operation mix per phase: filling phases reach a full list often,
    // draining phases empty it again, mixed phases churn in the middle.
    function automatic logic [OP_W-1:0] pick_op(input int mode);
        int r;
        int a, b, c, d, e, f;
        r = $urandom_range(0, 99);
        case (mode)
            FILL_PHASE:  begin a = 45; b = 75; c = 80; d = 88; e = 96; f = 97; end
            DRAIN_PHASE: begin a = 8;  b = 15; c = 70; d = 82; e = 92; f = 96; end
            default:     begin a = 20; b = 40; c = 60; d = 77; e = 92; f = 96; end
        endcase
        if (r < a) return OP_APPEND;
        if (r < b) return OP_INSERT;
        if (r < c) return OP_ERASE;
        if (r < d) return OP_READ;
        if (r < e) return OP_WRITE;
        if (r < f) return OP_CLEAR;
        return (r[0]) ? OP_SPARE_A : OP_SPARE_B;
    endfunction

    // Slot choice: mostly inside the list, now and then at or past capacity.
    // Erase leans to low slots so it lands below the fill count most times.
    function automatic logic [SLOT_W-1:0] pick_slot(input logic [OP_W-1:0] op);
        int r;
        r = $urandom_range(0, 99);
        case (op)
            OP_ERASE:
                if (r < 60)
                    return SLOT_W'($urandom_range(0, 4));
                else if (r < 90)
                    return SLOT_W'($urandom_range(0, CAPACITY - 1));
                else
                    return SLOT_W'($urandom_range(CAPACITY, 31));
            OP_INSERT, OP_READ, OP_WRITE:
                if (r < 85)
                    return SLOT_W'($urandom_range(0, CAPACITY - 1));
                else
                    return SLOT_W'($urandom_range(CAPACITY, 31));
            default:
                return SLOT_W'($urandom_range(0, 31));
        endcase
    endfunction

    // entry data: mostly random, with all-zero, all-one and walking-bit words mixed in
    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            3:       return ~(WORD_W'(1) << $urandom_range(0, WORD_W - 1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        int               mode;
        int               phase_left;
        logic [OP_W-1:0]  op;
        logic [SLOT_W-1:0] slot;

        for (int i = 0; i < 8; i++)
            op_tally[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed beats ----
        send_op(OP_READ,   5'd0, '0);                       // read of an empty list
        send_op(OP_ERASE,  5'd0, '1);                       // erase with nothing held
        send_op(OP_APPEND, 5'd31, '1);
        send_op(OP_APPEND, 5'd0, '0);
        send_op(OP_INSERT, 5'd0, 64'h8000_0000_0000_0001);  // insert at the head
        send_op(OP_INSERT, 5'd12, 64'h0123_4567_89AB_CDEF); // past the count: goes to the end
        send_op(OP_INSERT, SLOT_W'(CAPACITY), '1);          // at capacity: ignored
        send_op(OP_INSERT, 5'd31, '1);
        send_op(OP_READ,   5'd1, '0);
        send_op(OP_READ,   5'd31, '0);                      // out of range
        send_op(OP_WRITE,  SLOT_W'(CAPACITY - 1), 64'hA5A5_5A5A_F0F0_0F0F); // above count
        send_op(OP_READ,   SLOT_W'(CAPACITY - 1), '0);
        send_op(OP_WRITE,  SLOT_W'(CAPACITY), '1);          // out of range
        send_op(OP_ERASE,  5'd4, '0);                       // at the count: ignored
        send_op(OP_ERASE,  5'd0, '0);
        send_op(OP_ERASE,  5'd2, '0);                       // last entry
        send_op(OP_SPARE_A, 5'd7, '1);
        send_op(OP_SPARE_B, 5'd24, '1);
        send_op(OP_CLEAR,  5'd0, '0);
        send_op(OP_READ,   SLOT_W'(CAPACITY - 1), '0);      // cleared slot reads zero

        // ---- random phases, opening with a fill so full-list cases come early ----
        mode       = FILL_PHASE;
        phase_left = $urandom_range(40, 120);
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (phase_left == 0)
            begin
                mode       = $urandom_range(FILL_PHASE, MIXED_PHASE);
                phase_left = $urandom_range(30, 120);
            end
            phase_left--;
            op   = pick_op(mode);
            slot = pick_slot(op);
            send_op(op, slot, pick_word());
        end
        s_axis_tvalid <= 1'b0;

        // drain: let the last beat reach the checker's books, then wait
        // until every prediction is answered before the verdict
        @(posedge clk);
        wait (outstanding == 0);
        repeat (8) @(posedge clk);

        $display("Covered ops: append %0d insert %0d erase %0d read %0d write %0d clear %0d",
                 op_tally[OP_APPEND], op_tally[OP_INSERT], op_tally[OP_ERASE],
                 op_tally[OP_READ], op_tally[OP_WRITE], op_tally[OP_CLEAR]);
        $display("Unused codes %0d, result beats compared %0d, mismatches %0d",
                 op_tally[OP_SPARE_A] + op_tally[OP_SPARE_B], beats_checked, mismatches);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("Timeout: run did not finish");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
